// ===== rtl/slotted_page_record_manager_assert.svh =====
// Assertion macros for the slotted page record manager
`ifndef SLOTTED_PAGE_RECORD_MANAGER_ASSERT_SVH
`define SLOTTED_PAGE_RECORD_MANAGER_ASSERT_SVH
// Property that holds at every clock edge outside reset
`define SPRM_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
// Same-cycle implication
`define SPRM_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`endif

// ===== rtl/sprm_pkg.sv =====
// ----------------------------------------------------------------------------
// sprm_pkg
// Types and codes of the slotted page record manager.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package sprm_pkg;

	localparam logic [2:0] OP_APPEND = 3'd0;
	localparam logic [2:0] OP_UPDATE = 3'd1;
	localparam logic [2:0] OP_REMOVE = 3'd2;
	localparam logic [2:0] OP_READ   = 3'd3;
	localparam logic [2:0] OP_DEFRAG = 3'd4;

	localparam logic [1:0] STAT_DONE  = 2'd0;
	localparam logic [1:0] STAT_SPACE = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;
	localparam logic [1:0] STAT_MOVED = 2'd3;

	typedef enum logic [13:0] {
		ST_IDLE   = 14'b00000000000001,
		ST_SLOT   = 14'b00000000000010,
		ST_LEN1   = 14'b00000000000100,
		ST_LEN2   = 14'b00000000001000,
		ST_RDB    = 14'b00000000010000,
		ST_TRIM   = 14'b00000000100000,
		ST_TRIMRD = 14'b00000001000000,
		ST_ALLOC  = 14'b00000010000000,
		ST_DSCAN  = 14'b00000100000000,
		ST_DMOVE  = 14'b00001000000000,
		ST_PISSUE = 14'b00010000000000,
		ST_CPR    = 14'b00100000000000,
		ST_CPW    = 14'b01000000000000,
		ST_PSET   = 14'b10000000000000
	} state_t;

	typedef enum logic [2:0] {
		J_UPD  = 3'd0,
		J_REM  = 3'd1,
		J_RD   = 3'd2,
		J_DMV  = 3'd3,
		J_PACK = 3'd4
	} job_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  slot;
		logic [5:0]  from;
		logic [7:0]  rb;
		logic [11:0] len;
		logic        last;
	} res_t;

	function automatic res_t mk_res(logic [1:0] st, logic [5:0] sl, logic [5:0] fr,
		logic [7:0] rb, logic [11:0] ln, logic lst);
		res_t r;
		r.status = st;
		r.slot   = sl;
		r.from   = fr;
		r.rb     = rb;
		r.len    = ln;
		r.last   = lst;
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/sprm_ram.sv =====
// ----------------------------------------------------------------------------
// sprm_ram
// Generic simple dual-port RAM, one write port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sprm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/slotted_page_record_manager.sv =====
// ----------------------------------------------------------------------------
// slotted_page_record_manager
// Slotted page: records packed down from the page end, slot table growing up.
// Append/update byte words and stray bytes: result registered in the cycle after acceptance,
// busy stays low, one word per cycle.
// Update/remove/read: slot RAM read, then both length bytes from the page RAM,
// then the data byte read, a slot table trim when the top slot frees, or a new allocation.
// Defrag: a scan moves live slot entries down, then each record is repacked
// toward the page end by a byte-wise page RAM read then write. No clearing pass:
// reset clears the slot valid bits at once; page bytes are undefined until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module slotted_page_record_manager #(
	parameter int PAGE_BYTES   = 4096,
	parameter int HEADER_BYTES = 32,
	parameter int MAX_SLOTS    = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  operation,
	input  wire logic [5:0]  slot_index,
	input  wire logic [11:0] record_size,
	input  wire logic [11:0] byte_offset,
	input  wire logic [7:0]  data_byte,
	output logic             done,
	output logic [1:0]       status,
	output logic [5:0]       result_slot,
	output logic [5:0]       moved_from,
	output logic [7:0]       read_byte,
	output logic [11:0]      record_length,
	output logic [11:0]      free_bytes,
	output logic [6:0]       record_count,
	output logic             last
);
	import sprm_pkg::*;
	`include "slotted_page_record_manager_assert.svh"

	localparam int AW   = $clog2(PAGE_BYTES);
	localparam int OW   = $clog2(PAGE_BYTES + 1);
	localparam int LW   = (OW > 12) ? OW + 1 : 13;
	localparam int XW   = (LW > 16) ? LW : 16;
	localparam int SW   = $clog2(MAX_SLOTS);
	localparam int CW   = $clog2(MAX_SLOTS + 1);
	localparam logic [LW-1:0] PAGE_L   = LW'(PAGE_BYTES);
	localparam logic [LW-1:0] HDR_L    = LW'(HEADER_BYTES);
	localparam logic [LW-1:0] FREE_MAX = LW'(PAGE_BYTES - HEADER_BYTES);
	localparam logic [CW-1:0] SLOTS_C  = CW'(MAX_SLOTS);

	function automatic logic [AW-1:0] pa(logic [LW-1:0] x);
		return (x >= PAGE_L) ? AW'(x - PAGE_L) : AW'(x);
	endfunction

	function automatic logic [LW-1:0] fadd(logic [LW-1:0] f, logic [LW-1:0] a);
		return (a >= FREE_MAX - f) ? FREE_MAX : f + a;
	endfunction

	state_t state_q, state_d;
	job_t   job_q, job_d;

	logic [5:0]    s_q, s_d;
	logic [LW-1:0] size_q, size_d;
	logic [LW-1:0] bo_q, bo_d;
	logic [7:0]    db_q, db_d;
	logic [LW-1:0] off_q, off_d;
	logic [7:0]    lo_q, lo_d;
	logic [LW-1:0] len_q, len_d;
	logic [SW-1:0] j_q, j_d;
	logic [CW-1:0] src_q, src_d;
	logic [CW-1:0] dest_q, dest_d;
	logic [LW-1:0] rec_end_q, rec_end_d;
	logic [LW-1:0] no_q, no_d;
	logic [LW-1:0] k_q, k_d;
	logic          desc_q, desc_d;
	logic [LW-1:0] free_q, free_d;
	logic [CW-1:0] live_q, live_d;
	logic [CW-1:0] n_q, n_d;
	logic [LW-1:0] rs_q, rs_d;
	logic [LW-1:0] wc_q, wc_d;
	logic          rej_q, rej_d;
	logic [5:0]    pslot_q, pslot_d;
	logic [LW-1:0] poff_q, poff_d;
	logic [MAX_SLOTS-1:0] valid_q, valid_d;
	logic          done_q, done_d;
	res_t          res_q, res_d;

	logic          p_we;
	logic [AW-1:0] p_waddr, p_raddr;
	logic [7:0]    p_wdata, p_rd;
	logic          s_we;
	logic [SW-1:0] s_waddr, s_raddr;
	logic [LW-1:0] s_wdata, s_rd;

	sprm_ram #(.WIDTH(8), .DEPTH(PAGE_BYTES)) u_page (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.raddr(p_raddr), .rdata(p_rd)
	);

	sprm_ram #(.WIDTH(LW), .DEPTH(MAX_SLOTS)) u_slots (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr(s_raddr), .rdata(s_rd)
	);

	// allocation check, shared by append and the move branch of update
	logic [LW-1:0] a_size, a_real, se, room, a_rs;
	logic [7:0]    a_db;
	logic          a_ok;
	// stored length of the record at off_q
	logic [15:0]   raw;
	logic [LW-1:0] lim, rlen, lim2, len2, no2;
	logic          in_live;
	logic [LW-1:0] in_size, in_bo;

	always_comb begin
		in_size = LW'(record_size);
		in_bo   = LW'(byte_offset);
		in_live = (CW'(slot_index) < SLOTS_C) && valid_q[slot_index[SW-1:0]];
		a_size  = (state_q == ST_IDLE) ? in_size : size_q;
		a_db    = (state_q == ST_IDLE) ? data_byte : db_q;
		a_real  = a_size + LW'(2);
		se      = HDR_L + (LW'(n_q) << 1);
		room    = (rs_q > se) ? rs_q - se : '0;
		a_ok    = (free_q >= a_real) && (a_real <= room) && (n_q < SLOTS_C);
		a_rs    = rs_q - a_size;
		raw     = {p_rd, lo_q};
		lim     = PAGE_L - off_q;
		rlen    = (XW'(raw) > XW'(lim)) ? lim : LW'(raw);
		lim2    = rec_end_q - HDR_L;
		len2    = (rlen > lim2) ? lim2 : rlen;
		no2     = rec_end_q - len2;
	end

	always_comb begin
		state_d   = state_q;
		job_d     = job_q;
		s_d       = s_q;
		size_d    = size_q;
		bo_d      = bo_q;
		db_d      = db_q;
		off_d     = off_q;
		lo_d      = lo_q;
		len_d     = len_q;
		j_d       = j_q;
		src_d     = src_q;
		dest_d    = dest_q;
		rec_end_d = rec_end_q;
		no_d      = no_q;
		k_d       = k_q;
		desc_d    = desc_q;
		free_d    = free_q;
		live_d    = live_q;
		n_d       = n_q;
		rs_d      = rs_q;
		wc_d      = wc_q;
		rej_d     = rej_q;
		pslot_d   = pslot_q;
		poff_d    = poff_q;
		valid_d   = valid_q;
		done_d    = 1'b0;
		res_d     = res_q;
		p_we      = 1'b0;
		p_waddr   = '0;
		p_wdata   = '0;
		p_raddr   = '0;
		s_we      = 1'b0;
		s_waddr   = '0;
		s_wdata   = '0;
		s_raddr   = '0;

		case (state_q)
			ST_IDLE: begin
				if (start) begin
					s_d    = slot_index;
					size_d = in_size;
					bo_d   = in_bo;
					db_d   = data_byte;
					done_d = 1'b1;
					if ((operation == OP_APPEND || operation == OP_UPDATE) && byte_offset != '0) begin
						if (rej_q) begin
							res_d = mk_res(STAT_SPACE, '0, '0, '0, '0, 1'b1);
						end else if (wc_q != '0) begin
							if (in_bo < wc_q) begin
								p_we    = 1'b1;
								p_waddr = pa(poff_q + in_bo);
								p_wdata = data_byte;
								if (in_bo == wc_q - LW'(1)) begin
									wc_d = '0;
								end
							end
							res_d = mk_res(STAT_DONE, pslot_q, '0, '0, 12'(wc_q), 1'b1);
						end else begin
							res_d = mk_res(STAT_EMPTY, '0, '0, '0, '0, 1'b1);
						end
					end else begin
						case (operation)
							OP_APPEND: begin
								wc_d  = '0;
								rej_d = 1'b0;
								if (in_size < LW'(2) || !a_ok) begin
									rej_d = 1'b1;
									res_d = mk_res(STAT_SPACE, '0, '0, '0, '0, 1'b1);
								end else begin
									s_we     = 1'b1;
									s_waddr  = n_q[SW-1:0];
									s_wdata  = a_rs;
									valid_d[n_q[SW-1:0]] = 1'b1;
									p_we     = 1'b1;
									p_waddr  = pa(a_rs);
									p_wdata  = a_db;
									rs_d     = a_rs;
									n_d      = n_q + CW'(1);
									live_d   = live_q + CW'(1);
									free_d   = free_q - a_real;
									pslot_d  = 6'(n_q);
									poff_d   = a_rs;
									wc_d     = a_size;
									res_d    = mk_res(STAT_DONE, 6'(n_q), '0, '0, 12'(a_size), 1'b1);
								end
							end
							OP_UPDATE: begin
								wc_d  = '0;
								rej_d = 1'b0;
								if (in_size < LW'(2)) begin
									rej_d = 1'b1;
									res_d = mk_res(STAT_SPACE, slot_index, '0, '0, '0, 1'b1);
								end else if (!in_live) begin
									rej_d = 1'b1;
									res_d = mk_res(STAT_EMPTY, slot_index, '0, '0, '0, 1'b1);
								end else begin
									done_d  = 1'b0;
									s_raddr = slot_index[SW-1:0];
									job_d   = J_UPD;
									state_d = ST_SLOT;
								end
							end
							OP_REMOVE: begin
								wc_d  = '0;
								rej_d = 1'b0;
								if (!in_live) begin
									res_d = mk_res(STAT_EMPTY, slot_index, '0, '0, '0, 1'b1);
								end else begin
									done_d  = 1'b0;
									s_raddr = slot_index[SW-1:0];
									job_d   = J_REM;
									state_d = ST_SLOT;
								end
							end
							OP_READ: begin
								if (!in_live) begin
									res_d = mk_res(STAT_EMPTY, slot_index, '0, '0, '0, 1'b1);
								end else begin
									done_d  = 1'b0;
									s_raddr = slot_index[SW-1:0];
									job_d   = J_RD;
									state_d = ST_SLOT;
								end
							end
							OP_DEFRAG: begin
								wc_d  = '0;
								rej_d = 1'b0;
								if (n_q == '0) begin
									res_d = mk_res(STAT_DONE, '0, '0, '0, '0, 1'b1);
								end else begin
									done_d  = 1'b0;
									src_d   = '0;
									dest_d  = '0;
									state_d = ST_DSCAN;
								end
							end
							default: begin
								res_d = mk_res(STAT_DONE, '0, '0, '0, '0, 1'b1);
							end
						endcase
					end
				end
			end
			ST_SLOT: begin
				off_d   = s_rd;
				p_raddr = pa(s_rd);
				state_d = ST_LEN1;
			end
			ST_LEN1: begin
				lo_d    = p_rd;
				p_raddr = pa(off_q + LW'(1));
				state_d = ST_LEN2;
			end
			ST_LEN2: begin
				len_d = rlen;
				case (job_q)
					J_UPD, J_REM: begin
						if (job_q == J_UPD && rlen >= size_q) begin
							free_d  = fadd(free_q, rlen - size_q);
							p_we    = 1'b1;
							p_waddr = pa(off_q);
							p_wdata = db_q;
							pslot_d = s_q;
							poff_d  = off_q;
							wc_d    = size_q;
							done_d  = 1'b1;
							res_d   = mk_res(STAT_DONE, s_q, '0, '0, 12'(size_q), 1'b1);
							state_d = ST_IDLE;
						end else begin
							free_d = fadd(free_q, rlen + LW'(2));
							valid_d[s_q[SW-1:0]] = 1'b0;
							live_d = (live_q != '0) ? live_q - CW'(1) : '0;
							if (n_q != '0 && CW'(s_q) == n_q - CW'(1)) begin
								j_d     = s_q[SW-1:0];
								state_d = ST_TRIM;
							end else if (job_q == J_UPD) begin
								state_d = ST_ALLOC;
							end else begin
								done_d  = 1'b1;
								res_d   = mk_res(STAT_DONE, s_q, '0, '0, 12'(rlen), 1'b1);
								state_d = ST_IDLE;
							end
						end
					end
					J_RD: begin
						if (bo_q < rlen) begin
							p_raddr = pa(off_q + bo_q);
							state_d = ST_RDB;
						end else begin
							done_d  = 1'b1;
							res_d   = mk_res(STAT_DONE, s_q, '0, '0, 12'(rlen), 1'b1);
							state_d = ST_IDLE;
						end
					end
					J_DMV: begin
						done_d  = 1'b1;
						res_d   = mk_res(STAT_MOVED, 6'(dest_q), 6'(src_q), '0, 12'(rlen), 1'b0);
						dest_d  = dest_q + CW'(1);
						src_d   = src_q + CW'(1);
						state_d = ST_DSCAN;
					end
					J_PACK: begin
						len_d = len2;
						no_d  = no2;
						if (no2 != off_q && len2 != '0) begin
							if (no2 > off_q) begin
								desc_d = 1'b1;
								k_d    = len2 - LW'(1);
							end else begin
								desc_d = 1'b0;
								k_d    = '0;
							end
							state_d = ST_CPR;
						end else begin
							state_d = ST_PSET;
						end
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_RDB: begin
				done_d  = 1'b1;
				res_d   = mk_res(STAT_DONE, s_q, '0, p_rd, 12'(len_q), 1'b1);
				state_d = ST_IDLE;
			end
			ST_TRIM: begin
				if (j_q != '0 && !valid_q[j_q]) begin
					j_d = j_q - SW'(1);
				end else if (!valid_q[j_q]) begin
					rs_d = PAGE_L;
					n_d  = '0;
					if (job_q == J_UPD) begin
						state_d = ST_ALLOC;
					end else begin
						done_d  = 1'b1;
						res_d   = mk_res(STAT_DONE, s_q, '0, '0, 12'(len_q), 1'b1);
						state_d = ST_IDLE;
					end
				end else begin
					s_raddr = j_q;
					state_d = ST_TRIMRD;
				end
			end
			ST_TRIMRD: begin
				rs_d = s_rd;
				n_d  = CW'(j_q) + CW'(1);
				if (job_q == J_UPD) begin
					state_d = ST_ALLOC;
				end else begin
					done_d  = 1'b1;
					res_d   = mk_res(STAT_DONE, s_q, '0, '0, 12'(len_q), 1'b1);
					state_d = ST_IDLE;
				end
			end
			ST_ALLOC: begin
				done_d  = 1'b1;
				state_d = ST_IDLE;
				if (!a_ok) begin
					rej_d = 1'b1;
					res_d = mk_res(STAT_SPACE, s_q, '0, '0, '0, 1'b1);
				end else begin
					s_we     = 1'b1;
					s_waddr  = n_q[SW-1:0];
					s_wdata  = a_rs;
					valid_d[n_q[SW-1:0]] = 1'b1;
					p_we     = 1'b1;
					p_waddr  = pa(a_rs);
					p_wdata  = a_db;
					rs_d     = a_rs;
					n_d      = n_q + CW'(1);
					live_d   = live_q + CW'(1);
					free_d   = free_q - a_real;
					pslot_d  = 6'(n_q);
					poff_d   = a_rs;
					wc_d     = a_size;
					res_d    = mk_res(STAT_DONE, 6'(n_q), '0, '0, 12'(a_size), 1'b1);
				end
			end
			ST_DSCAN: begin
				if (src_q == n_q) begin
					n_d       = dest_q;
					src_d     = '0;
					rec_end_d = PAGE_L;
					state_d   = ST_PISSUE;
				end else if (!valid_q[src_q[SW-1:0]]) begin
					src_d = src_q + CW'(1);
				end else if (src_q != dest_q) begin
					s_raddr = src_q[SW-1:0];
					state_d = ST_DMOVE;
				end else begin
					src_d  = src_q + CW'(1);
					dest_d = dest_q + CW'(1);
				end
			end
			ST_DMOVE: begin
				s_we    = 1'b1;
				s_waddr = dest_q[SW-1:0];
				s_wdata = s_rd;
				valid_d[dest_q[SW-1:0]] = 1'b1;
				valid_d[src_q[SW-1:0]]  = 1'b0;
				off_d   = s_rd;
				p_raddr = pa(s_rd);
				job_d   = J_DMV;
				state_d = ST_LEN1;
			end
			ST_PISSUE: begin
				if (src_q == n_q) begin
					rs_d    = rec_end_q;
					done_d  = 1'b1;
					res_d   = mk_res(STAT_DONE, '0, '0, '0, '0, 1'b1);
					state_d = ST_IDLE;
				end else begin
					s_raddr = src_q[SW-1:0];
					job_d   = J_PACK;
					state_d = ST_SLOT;
				end
			end
			ST_CPR: begin
				p_raddr = pa(off_q + k_q);
				state_d = ST_CPW;
			end
			ST_CPW: begin
				p_we    = 1'b1;
				p_waddr = pa(no_q + k_q);
				p_wdata = p_rd;
				if (desc_q ? (k_q == '0) : (k_q == len_q - LW'(1))) begin
					state_d = ST_PSET;
				end else begin
					k_d     = desc_q ? k_q - LW'(1) : k_q + LW'(1);
					state_d = ST_CPR;
				end
			end
			ST_PSET: begin
				s_we      = 1'b1;
				s_waddr   = src_q[SW-1:0];
				s_wdata   = no_q;
				rec_end_d = no_q;
				src_d     = src_q + CW'(1);
				state_d   = ST_PISSUE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			free_q  <= FREE_MAX;
			live_q  <= '0;
			n_q     <= '0;
			rs_q    <= PAGE_L;
			wc_q    <= '0;
			rej_q   <= 1'b0;
			valid_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			free_q  <= free_d;
			live_q  <= live_d;
			n_q     <= n_d;
			rs_q    <= rs_d;
			wc_q    <= wc_d;
			rej_q   <= rej_d;
			valid_q <= valid_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		job_q     <= job_d;
		s_q       <= s_d;
		size_q    <= size_d;
		bo_q      <= bo_d;
		db_q      <= db_d;
		off_q     <= off_d;
		lo_q      <= lo_d;
		len_q     <= len_d;
		j_q       <= j_d;
		src_q     <= src_d;
		dest_q    <= dest_d;
		rec_end_q <= rec_end_d;
		no_q      <= no_d;
		k_q       <= k_d;
		desc_q    <= desc_d;
		pslot_q   <= pslot_d;
		poff_q    <= poff_d;
		res_q     <= res_d;
	end

	assign busy          = (state_q != ST_IDLE);
	assign done          = done_q;
	assign status        = res_q.status;
	assign result_slot   = res_q.slot;
	assign moved_from    = res_q.from;
	assign read_byte     = res_q.rb;
	assign record_length = res_q.len;
	assign last          = res_q.last;
	assign free_bytes    = 12'(free_q);
	assign record_count  = 7'(live_q);

	`SPRM_IMPLIES(a_last_frees, done && last, !busy, "final word while still busy")
	`SPRM_IMPLIES(a_move_only, done && !last, status == STAT_MOVED, "non-final word is not a move")
	`SPRM_ALWAYS(a_count_bound, record_count <= 7'(MAX_SLOTS), "record count beyond slot table")
	`SPRM_IMPLIES(a_move_busy, done && !last, busy, "defrag move word after sequencer ended")

endmodule
`default_nettype wire

// ===== test/slotted_page_record_manager_test.sv =====
// ----------------------------------------------------------------------------
// slotted_page_record_manager_test
// Streams append, update, remove, read and defrag words into the slotted page.
// A page predictor in the bench computes every result word. Each word the
// block strobes out is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module slotted_page_record_manager_test;
	import sprm_pkg::*;

	localparam int PAGE   = 4096;
	localparam int HDR    = 32;
	localparam int NSLOTS = 64;
	localparam int FREE_MAX = PAGE - HDR;
	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  slot;
		logic [5:0]  from;
		logic [7:0]  rb;
		logic [11:0] len;
		logic [11:0] free;
		logic [6:0]  count;
		logic        last;
	} page_word_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  operation;
	logic [5:0]  slot_index;
	logic [11:0] record_size;
	logic [11:0] byte_offset;
	logic [7:0]  data_byte;
	logic        done;
	logic [1:0]  status;
	logic [5:0]  result_slot;
	logic [5:0]  moved_from;
	logic [7:0]  read_byte;
	logic [11:0] record_length;
	logic [11:0] free_bytes;
	logic [6:0]  record_count;
	logic        last;

	slotted_page_record_manager DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .slot_index(slot_index), .record_size(record_size),
		.byte_offset(byte_offset), .data_byte(data_byte), .done(done),
		.status(status), .result_slot(result_slot), .moved_from(moved_from),
		.read_byte(read_byte), .record_length(record_length),
		.free_bytes(free_bytes), .record_count(record_count), .last(last)
	);

	// page predictor state
	logic [7:0]  page_mem [PAGE];
	bit          page_known [PAGE];
	int unsigned slot_off [NSLOTS];
	int unsigned free_sp, live, slot_end, rec_start, wcur, rej, pend;

	page_word_t expected_words[$];
	bit  failed;
	int  words_sent, words_checked, defrags_run, peak_live, quiet_left;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#16ms;
		$display("slotted_page_record_manager: mismatch");
		$finish;
	end

	function automatic int unsigned pg_rd(int unsigned a);
		return page_mem[a % PAGE];
	endfunction

	function automatic int unsigned slot_cnt();
		return (slot_end - HDR) / 2;
	endfunction

	function automatic bit slot_used(int unsigned s);
		return s < NSLOTS && slot_off[s] != 0;
	endfunction

	function automatic int unsigned stored_len(int unsigned s);
		int unsigned off, len, lim;
		off = slot_off[s];
		len = pg_rd(off) | (pg_rd(off + 1) << 8);
		lim = off < PAGE ? PAGE - off : 0;
		return len > lim ? lim : len;
	endfunction

	function automatic void free_add(int unsigned n);
		free_sp = (n >= FREE_MAX - free_sp) ? FREE_MAX : free_sp + n;
	endfunction

	function automatic void expect_word(int unsigned st, int unsigned sl, int unsigned fr,
		int unsigned rb, int unsigned len, int unsigned lst);
		page_word_t w;
		w.status = st[1:0];
		w.slot   = sl[5:0];
		w.from   = fr[5:0];
		w.rb     = rb[7:0];
		w.len    = len[11:0];
		w.free   = free_sp[11:0];
		w.count  = live[6:0];
		w.last   = lst[0];
		expected_words.push_back(w);
	endfunction

	function automatic int unsigned drop_record(int unsigned s);
		int unsigned len, n, j;
		len = stored_len(s);
		n = slot_cnt();
		free_add(len + 2);
		slot_off[s] = 0;
		if (live > 0)
			live--;
		if (n > 0 && s == n - 1) begin
			j = s;
			while (j > 0 && slot_off[j] == 0)
				j--;
			if (slot_off[j] == 0) begin
				rec_start = PAGE;
				slot_end = HDR;
			end else begin
				rec_start = slot_off[j];
				slot_end = HDR + 2 * (j + 1);
			end
		end
		return len;
	endfunction

	function automatic int place_record(int unsigned size);
		int unsigned n, room;
		n = slot_cnt();
		room = rec_start > slot_end ? rec_start - slot_end : 0;
		if (size < 2 || free_sp < size + 2 || size + 2 > room || n >= NSLOTS)
			return -1;
		rec_start -= size;
		slot_off[n] = rec_start;
		slot_end += 2;
		live++;
		free_sp -= size + 2;
		return n;
	endfunction

	function automatic void put_byte(int unsigned a, int unsigned db);
		page_mem[a % PAGE] = db[7:0];
		page_known[a % PAGE] = 1;
	endfunction

	function automatic void open_record(int unsigned s, int unsigned size, int unsigned db);
		pend = s;
		wcur = size;
		put_byte(slot_off[s], db);
	endfunction

	function automatic void compact_page();
		int unsigned n, dest, src, rec_end, off, len, no, i, k;
		logic [7:0] tmp [];
		bit tmpk [];
		n = slot_cnt();
		if (n > 0) begin
			dest = 0;
			rec_end = PAGE;
			for (src = 0; src < n; src++) begin
				if (slot_off[src] != 0) begin
					if (src != dest) begin
						slot_off[dest] = slot_off[src];
						slot_off[src] = 0;
						expect_word(STAT_MOVED, dest, src, 0, stored_len(dest), 0);
					end
					dest++;
				end
			end
			slot_end = HDR + 2 * dest;
			for (i = 0; i < dest; i++) begin
				off = slot_off[i];
				len = stored_len(i);
				if (len > rec_end - HDR)
					len = rec_end - HDR;
				no = rec_end - len;
				if (no != off && off < PAGE) begin
					tmp = new[len];
					tmpk = new[len];
					for (k = 0; k < len; k++) begin
						tmp[k] = page_mem[off + k];
						tmpk[k] = page_known[off + k];
					end
					for (k = 0; k < len; k++) begin
						page_mem[no + k] = tmp[k];
						page_known[no + k] = tmpk[k];
					end
				end
				slot_off[i] = no;
				rec_end = no;
			end
			rec_start = rec_end;
		end
		expect_word(STAT_DONE, 0, 0, 0, 0, 1);
	endfunction

	function automatic void predict_page_op(logic [2:0] op, int unsigned s, int unsigned size,
		int unsigned bo, int unsigned db);
		int unsigned len, rb;
		int k;
		if ((op == OP_APPEND || op == OP_UPDATE) && bo != 0) begin
			if (rej)
				expect_word(STAT_SPACE, 0, 0, 0, 0, 1);
			else if (wcur != 0) begin
				len = wcur;
				if (bo < len) begin
					put_byte(slot_off[pend] + bo, db);
					if (bo == len - 1)
						wcur = 0;
				end
				expect_word(STAT_DONE, pend, 0, 0, len, 1);
			end else
				expect_word(STAT_EMPTY, 0, 0, 0, 0, 1);
			return;
		end
		case (op)
			OP_APPEND, OP_UPDATE: begin
				wcur = 0;
				rej = 0;
				if (size < 2) begin
					rej = 1;
					expect_word(STAT_SPACE, op == OP_UPDATE ? s : 0, 0, 0, 0, 1);
					return;
				end
				if (op == OP_UPDATE) begin
					if (!slot_used(s)) begin
						rej = 1;
						expect_word(STAT_EMPTY, s, 0, 0, 0, 1);
						return;
					end
					len = stored_len(s);
					if (len >= size) begin
						free_add(len - size);
						open_record(s, size, db);
						expect_word(STAT_DONE, s, 0, 0, size, 1);
						return;
					end
					void'(drop_record(s));
				end
				k = place_record(size);
				if (k < 0) begin
					rej = 1;
					expect_word(STAT_SPACE, op == OP_UPDATE ? s : 0, 0, 0, 0, 1);
				end else begin
					open_record(k, size, db);
					expect_word(STAT_DONE, k, 0, 0, size, 1);
				end
			end
			OP_REMOVE: begin
				wcur = 0;
				rej = 0;
				if (!slot_used(s))
					expect_word(STAT_EMPTY, s, 0, 0, 0, 1);
				else begin
					len = drop_record(s);
					expect_word(STAT_DONE, s, 0, 0, len, 1);
				end
			end
			OP_READ: begin
				if (!slot_used(s))
					expect_word(STAT_EMPTY, s, 0, 0, 0, 1);
				else begin
					len = stored_len(s);
					rb = bo < len ? pg_rd(slot_off[s] + bo) : 0;
					expect_word(STAT_DONE, s, 0, rb, len, 1);
				end
			end
			OP_DEFRAG: begin
				wcur = 0;
				rej = 0;
				defrags_run++;
				compact_page();
			end
			default: expect_word(STAT_DONE, 0, 0, 0, 0, 1);
		endcase
	endfunction

	// result checker
	always @(posedge clk) begin
		page_word_t got, want;
		if (arst_n && done) begin
			got = {status, result_slot, moved_from, read_byte, record_length,
				free_bytes, record_count, last};
			if (expected_words.size() == 0) begin
				failed = 1;
				$display("%0t unexpected word: actual %h", $time, got);
			end else begin
				want = expected_words.pop_front();
				words_checked++;
				if (record_count > peak_live)
					peak_live = record_count;
				if (got !== want) begin
					failed = 1;
					$display("%0t expected st %0d slot %0d from %0d rb %h len %0d free %0d cnt %0d last %0d, actual st %0d slot %0d from %0d rb %h len %0d free %0d cnt %0d last %0d",
						$time, want.status, want.slot, want.from, want.rb, want.len,
						want.free, want.count, want.last, got.status, got.slot,
						got.from, got.rb, got.len, got.free, got.count, got.last);
				end
			end
		end
	end

	task automatic send(logic [2:0] op, int unsigned s, int unsigned size,
		int unsigned bo, int unsigned db);
		int gap;
		operation   <= op;
		slot_index  <= s[5:0];
		record_size <= size[11:0];
		byte_offset <= bo[11:0];
		data_byte   <= db[7:0];
		start       <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		predict_page_op(op, s, size, bo, db);
		words_sent++;
		if (quiet_left > 0) begin
			quiet_left--;
			gap = 0;
		end else begin
			gap = $urandom_range(0, 9);
			if ($urandom_range(0, 15) == 0)
				quiet_left = $urandom_range(10, 40);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// a pending record must get its length bytes before anything cuts it
	task automatic fill_length();
		if (wcur != 0 && !rej && !page_known[(slot_off[pend] + 1) % PAGE])
			send(OP_APPEND, 0, 0, 1, $urandom_range(0, 255));
	endtask

	function automatic int unsigned pick_slot();
		int unsigned s, i;
		s = $urandom_range(0, 63);
		if ($urandom_range(0, 3) != 0)
			for (i = 0; i < NSLOTS; i++)
				if (slot_used((s + i) % NSLOTS))
					return (s + i) % NSLOTS;
		return s;
	endfunction

	task automatic stream_record(logic [2:0] op, int unsigned s, int unsigned size,
		bit honest, int unsigned stop);
		int unsigned b;
		send(op, s, size, 0, honest ? size & 8'hFF : $urandom_range(0, 255));
		for (b = 1; b < size && b < stop; b++)
			send(op, s, size, b, b == 1 && honest ? size >> 8 : $urandom_range(0, 255));
	endtask

	task automatic test_directed();
		send(OP_READ, 0, 0, 0, 0);
		send(OP_REMOVE, 63, 0, 0, 0);
		send(OP_APPEND, 0, 0, 5, 8'h5A);
		send(OP_SPARE_LO, 0, 0, 0, 0);
		send(OP_SPARE_HI, 63, 4095, 4095, 255);
		send(OP_APPEND, 0, 0, 0, 8'h11);
		send(OP_APPEND, 0, 0, 1, 8'h22);
		send(OP_APPEND, 0, 4062, 0, 8'hDE);
		send(OP_APPEND, 0, 4062, 1, 8'h0F);
		send(OP_APPEND, 0, 4095, 0, 8'hFF);
		send(OP_UPDATE, 0, 1, 0, 0);
		send(OP_UPDATE, 5, 4, 0, 0);
		send(OP_READ, 0, 0, 0, 0);
		send(OP_READ, 0, 0, 4095, 0);
		send(OP_REMOVE, 0, 0, 0, 0);
		stream_record(OP_APPEND, 0, 2, 1, 99);
		stream_record(OP_APPEND, 0, 3, 1, 99);
		send(OP_APPEND, 0, 2, 0, 8'hFF);
		send(OP_APPEND, 0, 2, 1, 8'hFF);
		stream_record(OP_UPDATE, 0, 2, 1, 99);
		stream_record(OP_UPDATE, 1, 10, 1, 2);
		send(OP_UPDATE, 1, 10, 4095, 8'h00);
		send(OP_REMOVE, 0, 0, 0, 0);
		send(OP_DEFRAG, 0, 0, 0, 0);
		send(OP_READ, 63, 0, 0, 0);
		drain();
	endtask

	task automatic test_random(int unsigned quota);
		int unsigned r, s, size, bo, len;
		while (words_sent < quota) begin
			fill_length();
			r = $urandom_range(0, 99);
			s = pick_slot();
			size = $urandom_range(0, 15) == 0 ? $urandom_range(2, 300) : $urandom_range(2, 12);
			if (r < 40)
				stream_record(OP_APPEND, 0, size, $urandom_range(0, 7) != 0,
					$urandom_range(0, 5) == 0 ? $urandom_range(2, 4) : 4096);
			else if (r < 55)
				stream_record(OP_UPDATE, s, size, $urandom_range(0, 7) != 0,
					$urandom_range(0, 5) == 0 ? $urandom_range(2, 4) : 4096);
			else if (r < 67)
				send(OP_REMOVE, s, 0, 0, 0);
			else if (r < 82) begin
				bo = $urandom_range(0, 3) == 0 ? $urandom_range(0, 4095) : $urandom_range(0, 15);
				if (slot_used(s)) begin
					len = stored_len(s);
					if (bo < len && !page_known[(slot_off[s] + bo) % PAGE])
						bo = len;
				end
				send(OP_READ, s, $urandom_range(0, 4095), bo, $urandom_range(0, 255));
			end else if (r < 86)
				send(OP_DEFRAG, s, 0, 0, 0);
			else if (r < 90)
				send($urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI,
					$urandom_range(0, 63), $urandom_range(0, 4095),
					$urandom_range(0, 4095), $urandom_range(0, 255));
			else if (r < 94)
				send($urandom_range(0, 1) ? OP_APPEND : OP_UPDATE, s,
					$urandom_range(0, 4095), $urandom_range(1, 4095), $urandom_range(0, 255));
			else
				stream_record($urandom_range(0, 1) ? OP_APPEND : OP_UPDATE, s,
					$urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(1000, 4095),
					0, 3);
		end
	endtask

	task automatic test_pause();
		drain();
		send(OP_DEFRAG, 0, 0, 0, 0);
		drain();
	endtask

	initial begin
		int unsigned i, wait_cycles;
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_APPEND;
		slot_index = '0;
		record_size = '0;
		byte_offset = '0;
		data_byte = '0;
		for (i = 0; i < PAGE; i++) begin
			page_mem[i] = '0;
			page_known[i] = 0;
		end
		for (i = 0; i < NSLOTS; i++)
			slot_off[i] = 0;
		free_sp = FREE_MAX;
		live = 0;
		slot_end = HDR;
		rec_start = PAGE;
		wcur = 0;
		rej = 0;
		pend = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(260);
		test_pause();
		test_random(500);
		fill_length();
		start <= 1'b0;
		wait_cycles = 0;
		while (expected_words.size() != 0 && wait_cycles < 200000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (50) @(posedge clk);
		if (expected_words.size() != 0)
			failed = 1;
		$display("%0d words sent, %0d result words checked", words_sent, words_checked);
		$display("%0d defrags, up to %0d live records on the page", defrags_run, peak_live);
		if (!failed)
			$display("slotted_page_record_manager: match");
		else
			$display("slotted_page_record_manager: mismatch");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/sprm_pkg.sv
rtl/sprm_ram.sv
rtl/slotted_page_record_manager.sv
test/slotted_page_record_manager_test.sv
